// ----- rtl/cpi_pkg.sv -----
// ----------------------------------------------------------------------------
// cpi_pkg
// shared constants and status codes for the circle pair intersection block
// ----------------------------------------------------------------------------
package cpi_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int EPS_W = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    localparam int CFG_DW = 32;
    localparam int CFG_AW = 3;
    localparam logic REG_EPSILON = 1'b0;

    localparam int STAT_W = 2;
    localparam logic [STAT_W-1:0] ST_APART = 2'd0;
    localparam logic [STAT_W-1:0] ST_CROSS = 2'd1;
    localparam logic [STAT_W-1:0] ST_INNER = 2'd2;

endpackage

// ----- rtl/circle_pair_intersection.sv -----
// ----------------------------------------------------------------------------
// circle_pair_intersection
// pipelined intersection of two circles in signed fixed point
// ----------------------------------------------------------------------------
// Takes one circle pair per clock and returns one result per clock, in order,
// while the output is not stalled. The pipeline holds 3*COORD_BITS + 12
// register stages. Its length is set by the square root, which resolves one
// root bit per stage over 2*COORD_BITS stages, followed by the offset
// divider, which resolves one quotient bit per stage over COORD_BITS+1
// stages; the midpoint divider runs alongside the square root.
// A stall on the output freezes the whole pipeline. The epsilon register
// should only be written while no transfer is in flight.
module circle_pair_intersection #(
    parameter int COORD_BITS = cpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cpi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // stream in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_center_x, a_center_y, a_radius, b_center_x, b_center_y, b_radius
    input  logic [((6*COORD_BITS-2+7)/8)*8-1:0] s_tdata,
    // stream out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, first_x, first_y, second_x, second_y
    output logic [((2+4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpi_pkg::CFG_AW-1:0]    paddr,
    input  logic [cpi_pkg::CFG_DW-1:0]    pwdata,
    output logic [cpi_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CW   = COORD_BITS;
    localparam int FB   = FRAC_BITS;
    localparam int EW   = cpi_pkg::EPS_W;
    localparam int RW   = CW - 1;
    localparam int AW   = CW + 1;
    localparam int D2W  = 2 * AW + 1;
    localparam int KW   = D2W + 1;
    localparam int QHW  = 2 * CW;
    localparam int QW   = 4 * CW;
    localparam int L0W  = EW + CW;
    localparam int L1W  = EW + D2W - CW;
    localparam int LW   = EW + D2W + FB + 2;
    localparam int CMW  = (QW > LW) ? QW : LW;
    localparam int M0W  = CW + AW;
    localparam int M1W  = KW - CW + AW;
    localparam int NW   = KW + AW + 2;
    localparam int QTW  = CW + 1;
    localparam int SQN  = 2 * CW;
    localparam int SRW  = 2 * CW + 3;
    localparam int TW   = CW + 3;
    localparam int OW   = ((2 + 4 * CW + 7) / 8) * 8;
    localparam int SQ0  = 8;
    localparam int OP0  = SQ0 + SQN;
    localparam int DV0  = OP0 + 2;
    localparam int FIN  = DV0 + QTW;
    localparam int NST  = FIN + 1;

    localparam logic signed [TW-1:0] SMAX = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [TW-1:0] SMIN = {{(TW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0]    ax;
        logic [CW-1:0]    ay;
        logic [CW-1:0]    bx;
        logic [CW-1:0]    by;
        logic [RW-1:0]    ra;
        logic [RW-1:0]    rb;
        logic             dxneg;
        logic             dxpos;
        logic             dypos;
        logic             dyz;
        logic [AW-1:0]    adx;
        logic [AW-1:0]    ady;
        logic [CW-1:0]    sm;
        logic [RW-1:0]    df;
        logic [2*AW-1:0]  adx2;
        logic [2*AW-1:0]  ady2;
        logic [QHW-1:0]   sm2;
        logic [2*RW-1:0]  df2;
        logic [2*RW-1:0]  ra2;
        logic [2*RW-1:0]  rb2;
        logic [2*EW-1:0]  eps2;
        logic [D2W-1:0]   d2;
        logic [1:0]       stat;
        logic [KW-1:0]    kp;
        logic [QHW-1:0]   qa;
        logic [QHW-1:0]   qb;
        logic             kneg;
        logic [KW-1:0]    kmag;
        logic [QHW-1:0]   qp0;
        logic [QHW-1:0]   qp1;
        logic [QHW-1:0]   qp2;
        logic [QHW-1:0]   qp3;
        logic [L0W-1:0]   lp0;
        logic [L1W-1:0]   lp1;
        logic [QW-1:0]    q;
        logic [LW-1:0]    lim;
        logic [M0W-1:0]   mxp0;
        logic [M1W-1:0]   mxp1;
        logic [M0W-1:0]   myp0;
        logic [M1W-1:0]   myp1;
        logic             touch;
        logic [NW-1:0]    nx;
        logic [NW-1:0]    ny;
        logic [QTW-1:0]   tx;
        logic [QTW-1:0]   ty;
        logic [QW-1:0]    sqq;
        logic [SQN-1:0]   root;
        logic [SRW-1:0]   srem;
        logic [M0W-1:0]   oxp0;
        logic [M0W-1:0]   oxp1;
        logic [M0W-1:0]   oyp0;
        logic [M0W-1:0]   oyp1;
        logic [NW-1:0]    rx;
        logic [NW-1:0]    ry;
        logic [QTW-1:0]   ux;
        logic [QTW-1:0]   uy;
        logic [CW-1:0]    fx;
        logic [CW-1:0]    fy;
        logic [CW-1:0]    sx;
        logic [CW-1:0]    sy;
    } pl_t;

    logic [EW-1:0]  eps_reg;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    pl_t            pipe_reg  [0:NST-1];
    pl_t            pipe_next [0:NST-1];
    logic           adv;

    function automatic logic [CW-1:0] sat(input logic signed [TW-1:0] v);
        logic [CW-1:0] r;
        if (v > SMAX)
            r = SMAX[CW-1:0];
        else if (v < SMIN)
            r = SMIN[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= cpi_pkg::EPS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == cpi_pkg::REG_EPSILON)
        begin
            eps_reg <= pwdata[EW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == cpi_pkg::REG_EPSILON)
            prdata = cpi_pkg::CFG_DW'(eps_reg);
    end

    // whole pipeline moves together
    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[NST-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    always_comb
    begin
        pl_t                    p;
        pl_t                    n;
        logic signed [AW-1:0]   dx;
        logic signed [AW-1:0]   dy;
        logic                   far;
        logic                   con;
        logic [SRW-1:0]         rem2;
        logic [SRW-1:0]         trial;
        logic [NW-1:0]          dv;
        logic signed [TW-1:0]   mxs;
        logic signed [TW-1:0]   mys;
        logic signed [TW-1:0]   oxs;
        logic signed [TW-1:0]   oys;
        logic signed [TW-1:0]   txe;
        logic signed [TW-1:0]   tye;
        logic signed [TW-1:0]   uxe;
        logic signed [TW-1:0]   uye;

        // capture
        n    = '0;
        n.ax = s_tdata[CW-1:0];
        n.ay = s_tdata[2*CW-1:CW];
        n.ra = s_tdata[3*CW-2:2*CW];
        n.bx = s_tdata[4*CW-2:3*CW-1];
        n.by = s_tdata[5*CW-2:4*CW-1];
        n.rb = s_tdata[6*CW-3:5*CW-1];
        pipe_next[0] = n;

        // center difference and radius sum, difference
        p  = pipe_reg[0];
        n  = p;
        dx = $signed({p.bx[CW-1], p.bx}) - $signed({p.ax[CW-1], p.ax});
        dy = $signed({p.by[CW-1], p.by}) - $signed({p.ay[CW-1], p.ay});
        n.adx   = dx[AW-1] ? AW'(-dx) : AW'(dx);
        n.ady   = dy[AW-1] ? AW'(-dy) : AW'(dy);
        n.dxneg = dx[AW-1];
        n.dxpos = !dx[AW-1] && (dx != '0);
        n.dypos = !dy[AW-1] && (dy != '0);
        n.dyz   = (dy == '0);
        n.sm    = CW'({1'b0, p.ra}) + CW'({1'b0, p.rb});
        n.df    = (p.ra >= p.rb) ? (p.ra - p.rb) : (p.rb - p.ra);
        pipe_next[1] = n;

        // squares
        p = pipe_reg[1];
        n = p;
        n.adx2 = (2*AW)'(p.adx) * (2*AW)'(p.adx);
        n.ady2 = (2*AW)'(p.ady) * (2*AW)'(p.ady);
        n.sm2  = QHW'(p.sm) * QHW'(p.sm);
        n.df2  = (2*RW)'(p.df) * (2*RW)'(p.df);
        n.ra2  = (2*RW)'(p.ra) * (2*RW)'(p.ra);
        n.rb2  = (2*RW)'(p.rb) * (2*RW)'(p.rb);
        n.eps2 = (2*EW)'(eps_reg) * (2*EW)'(eps_reg);
        pipe_next[2] = n;

        // squared distance
        p = pipe_reg[2];
        n = p;
        n.d2 = D2W'(p.adx2) + D2W'(p.ady2);
        pipe_next[3] = n;

        // classification
        p   = pipe_reg[3];
        n   = p;
        far = p.d2 > D2W'(p.sm2);
        con = (p.d2 < D2W'(p.eps2)) || (p.d2 <= D2W'(p.df2)) || (p.d2 == '0);
        n.stat = far ? cpi_pkg::ST_APART : (con ? cpi_pkg::ST_INNER : cpi_pkg::ST_CROSS);
        n.kp   = KW'(p.d2) + KW'(p.ra2);
        n.qa   = QHW'(D2W'(p.sm2) - p.d2);
        n.qb   = QHW'(p.d2 - D2W'(p.df2));
        pipe_next[4] = n;

        // chord offset sign, partial products of the half-chord term
        p = pipe_reg[4];
        n = p;
        n.kneg = p.kp < KW'(p.rb2);
        n.kmag = n.kneg ? (KW'(p.rb2) - p.kp) : (p.kp - KW'(p.rb2));
        n.qp0  = QHW'(p.qa[CW-1:0])    * QHW'(p.qb[CW-1:0]);
        n.qp1  = QHW'(p.qa[CW-1:0])    * QHW'(p.qb[QHW-1:CW]);
        n.qp2  = QHW'(p.qa[QHW-1:CW])  * QHW'(p.qb[CW-1:0]);
        n.qp3  = QHW'(p.qa[QHW-1:CW])  * QHW'(p.qb[QHW-1:CW]);
        n.lp0  = L0W'(eps_reg) * L0W'(p.d2[CW-1:0]);
        n.lp1  = L1W'(eps_reg) * L1W'(p.d2[D2W-1:CW]);
        pipe_next[5] = n;

        // sum partials, midpoint partial products
        p = pipe_reg[5];
        n = p;
        n.q    = QW'(p.qp0) + (QW'(p.qp1) << CW) + (QW'(p.qp2) << CW)
               + (QW'(p.qp3) << (2*CW));
        n.lim  = (LW'(p.lp0) + (LW'(p.lp1) << CW)) << (FB + 2);
        n.mxp0 = M0W'(p.kmag[CW-1:0]) * M0W'(p.adx);
        n.mxp1 = M1W'(p.kmag[KW-1:CW]) * M1W'(p.adx);
        n.myp0 = M0W'(p.kmag[CW-1:0]) * M0W'(p.ady);
        n.myp1 = M1W'(p.kmag[KW-1:CW]) * M1W'(p.ady);
        pipe_next[6] = n;

        // tangency test, rounded dividends, root setup
        p = pipe_reg[6];
        n = p;
        n.touch = CMW'(p.q) <= CMW'(p.lim);
        n.nx    = ((NW'(p.mxp0) + (NW'(p.mxp1) << CW)) << 1) + (NW'(p.d2) << 1);
        n.ny    = ((NW'(p.myp0) + (NW'(p.myp1) << CW)) << 1) + (NW'(p.d2) << 1);
        n.tx    = '0;
        n.ty    = '0;
        n.sqq   = p.q;
        n.root  = '0;
        n.srem  = '0;
        pipe_next[7] = n;

        // square root one bit per stage, midpoint division alongside
        for (int j = 0; j < SQN; j++)
        begin
            p     = pipe_reg[SQ0+j-1];
            n     = p;
            rem2  = {p.srem[SRW-3:0], p.sqq[QW-1:QW-2]};
            trial = SRW'({p.root, 2'b01});
            if (rem2 >= trial)
            begin
                n.srem = rem2 - trial;
                n.root = {p.root[SQN-2:0], 1'b1};
            end
            else
            begin
                n.srem = rem2;
                n.root = {p.root[SQN-2:0], 1'b0};
            end
            n.sqq = p.sqq << 2;
            if (j < QTW)
            begin
                dv = (NW'(p.d2) << 2) << (QTW - 1 - j);
                if (p.nx >= dv)
                begin
                    n.nx = p.nx - dv;
                    n.tx[QTW-1-j] = 1'b1;
                end
                if (p.ny >= dv)
                begin
                    n.ny = p.ny - dv;
                    n.ty[QTW-1-j] = 1'b1;
                end
            end
            pipe_next[SQ0+j] = n;
        end

        // offset partial products
        p = pipe_reg[OP0-1];
        n = p;
        n.oxp0 = M0W'(p.root[CW-1:0])   * M0W'(p.ady);
        n.oxp1 = M0W'(p.root[SQN-1:CW]) * M0W'(p.ady);
        n.oyp0 = M0W'(p.root[CW-1:0])   * M0W'(p.adx);
        n.oyp1 = M0W'(p.root[SQN-1:CW]) * M0W'(p.adx);
        pipe_next[OP0] = n;

        // rounded offset dividends
        p = pipe_reg[OP0];
        n = p;
        n.rx = ((NW'(p.oxp0) + (NW'(p.oxp1) << CW)) << 1) + (NW'(p.d2) << 1);
        n.ry = ((NW'(p.oyp0) + (NW'(p.oyp1) << CW)) << 1) + (NW'(p.d2) << 1);
        n.ux = '0;
        n.uy = '0;
        pipe_next[OP0+1] = n;

        // offset division one bit per stage
        for (int j = 0; j < QTW; j++)
        begin
            p  = pipe_reg[DV0+j-1];
            n  = p;
            dv = (NW'(p.d2) << 2) << (QTW - 1 - j);
            if (p.rx >= dv)
            begin
                n.rx = p.rx - dv;
                n.ux[QTW-1-j] = 1'b1;
            end
            if (p.ry >= dv)
            begin
                n.ry = p.ry - dv;
                n.uy[QTW-1-j] = 1'b1;
            end
            pipe_next[DV0+j] = n;
        end

        // signs, points and saturation
        p   = pipe_reg[FIN-1];
        n   = p;
        txe = $signed({{(TW-QTW){1'b0}}, p.tx});
        tye = $signed({{(TW-QTW){1'b0}}, p.ty});
        uxe = $signed({{(TW-QTW){1'b0}}, p.ux});
        uye = $signed({{(TW-QTW){1'b0}}, p.uy});
        mxs = $signed({{(TW-CW){p.ax[CW-1]}}, p.ax})
            + ((p.dxneg != p.kneg) ? -txe : txe);
        mys = $signed({{(TW-CW){p.ay[CW-1]}}, p.ay})
            + ((!p.dyz && !p.dypos) != p.kneg ? -tye : tye);
        if (p.touch)
        begin
            oxs = '0;
            oys = '0;
        end
        else
        begin
            oxs = p.dypos ? -uxe : uxe;
            if (p.dyz)
                oys = p.dxpos ? -uye : uye;
            else
                oys = p.dxpos ? uye : -uye;
        end
        if (p.stat == cpi_pkg::ST_CROSS)
        begin
            n.fx = sat(mxs + oxs);
            n.fy = sat(mys + oys);
            n.sx = sat(mxs - oxs);
            n.sy = sat(mys - oys);
        end
        else
        begin
            n.fx = '0;
            n.fy = '0;
            n.sx = '0;
            n.sy = '0;
        end
        pipe_next[FIN] = n;
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = OW'({pipe_reg[NST-1].sy, pipe_reg[NST-1].sx,
                           pipe_reg[NST-1].fy, pipe_reg[NST-1].fx,
                           pipe_reg[NST-1].stat});

endmodule

// ----- rtl/cpi_checker.sv -----
// ----------------------------------------------------------------------------
// cpi_checker
// port-level checks for the circle pair intersection block
// ----------------------------------------------------------------------------
module cpi_checker #(
    parameter int COORD_BITS = cpi_pkg::COORD_BITS_DEF
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((2+4*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    input logic                                   pready
);

    // a held result keeps its transfer pending
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // input side only blocks while the output is blocked
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && !m_tready) |-> s_tready)
        else $error("input blocked without output stall");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == cpi_pkg::ST_APART
                   || m_tdata[1:0] == cpi_pkg::ST_CROSS
                   || m_tdata[1:0] == cpi_pkg::ST_INNER))
        else $error("bad status");

    // no points unless the circles cross
    a_zero_pts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != cpi_pkg::ST_CROSS
        |-> m_tdata[4*COORD_BITS+1:2] == '0)
        else $error("points set without crossing");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("register port not ready");

endmodule

bind circle_pair_intersection cpi_checker #(.COORD_BITS(COORD_BITS)) u_cpi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stream test of the circle pair intersection block
// ----------------------------------------------------------------------------
// Sends circle pairs through the input stream and computes the expected status
// and intersection points with exact wide integer arithmetic. Each output
// transfer is compared field by field with the oldest expected result. Runs
// cover several epsilon settings, random idle cycles on both sides, a long
// output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [30:0]        ra;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        rb;
    } pair_t;

    typedef struct packed {
        logic [cpi_pkg::STAT_W-1:0] status;
        logic [31:0]       fx;
        logic [31:0]       fy;
        logic [31:0]       sx;
        logic [31:0]       sy;
    } crossing_t;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 130;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [191:0]           s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [135:0]           m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [cpi_pkg::CFG_AW-1:0] paddr;
    logic [cpi_pkg::CFG_DW-1:0] pwdata;
    logic [cpi_pkg::CFG_DW-1:0] prdata;
    logic                   pready;

    crossing_t              crossings_due[$];
    logic [cpi_pkg::EPS_W-1:0] eps_model;
    int                     mismatches = 0;
    int                     cycle_count = 0;
    int                     rx_hold;
    bit                     calm;

    circle_pair_intersection dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic wide_t root_floor(wide_t a);
        wide_t r;
        wide_t t;
        r = '0;
        for (int i = 80; i >= 0; i--)
        begin
            t = r;
            t[i] = 1'b1;
            if (t * t <= a)
                r = t;
        end
        return r;
    endfunction

    // nearest, ties away from zero, clamped far above any real value
    function automatic longint round_quot(wide_t n, wide_t d);
        wide_t q;
        wide_t two;
        wide_t cap;
        two = 2;
        cap = wide_t'(1) << 60;
        q = (two * n + d) / (two * d);
        if (q > cap)
            q = cap;
        return longint'(q[63:0]);
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic crossing_t solve_circles(pair_t p, logic [cpi_pkg::EPS_W-1:0] eps);
        crossing_t res;
        longint    ax, ay, dx, dy, adx, ady, mx, my, t, ox, oy, oxm, oym;
        wide_t     wdx, wdy, wra, wrb, d2, s2, df, df2, ra2, rb2, kmag, den;
        wide_t     q, lim, weps, s;
        bit        kneg;
        res = '0;
        res.status = cpi_pkg::ST_APART;
        ax = p.ax;
        ay = p.ay;
        dx = longint'(p.bx) - ax;
        dy = longint'(p.by) - ay;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        wdx = adx;
        wdy = ady;
        wra = p.ra;
        wrb = p.rb;
        weps = eps;
        d2 = wdx * wdx + wdy * wdy;
        s2 = (wra + wrb) * (wra + wrb);
        if (d2 > s2)
            return res;
        df = wra >= wrb ? wra - wrb : wrb - wra;
        df2 = df * df;
        if (d2 < weps * weps || d2 <= df2 || d2 == 0)
        begin
            res.status = cpi_pkg::ST_INNER;
            return res;
        end
        ra2 = wra * wra;
        rb2 = wrb * wrb;
        kneg = (d2 + ra2) < rb2;
        kmag = kneg ? rb2 - (d2 + ra2) : (d2 + ra2) - rb2;
        den = d2 << 1;
        t = round_quot(kmag * wdx, den);
        mx = ax + (((dx < 0) != kneg) ? -t : t);
        t = round_quot(kmag * wdy, den);
        my = ay + (((dy < 0) != kneg) ? -t : t);
        ox = 0;
        oy = 0;
        q = (s2 - d2) * (d2 - df2);
        lim = (weps << 18) * d2;
        if (q > lim)
        begin
            s = root_floor(q);
            oxm = round_quot(s * wdy, den);
            oym = round_quot(s * wdx, den);
            ox = dy > 0 ? -oxm : oxm;
            if (dy != 0)
                oy = dx > 0 ? oym : -oym;
            else
                oy = dx > 0 ? -oym : oym;
        end
        res.status = cpi_pkg::ST_CROSS;
        res.fx = clamp32(mx + ox);
        res.fy = clamp32(my + oy);
        res.sx = clamp32(mx - ox);
        res.sy = clamp32(my - oy);
        return res;
    endfunction

    // output side: random stalls, plus a long hold when requested
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            n = calm ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        crossing_t got;
        crossing_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[1:0];
            got.fx = m_tdata[33:2];
            got.fy = m_tdata[65:34];
            got.sx = m_tdata[97:66];
            got.sy = m_tdata[129:98];
            if (crossings_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transfer: %p", got);
            end
            else
            begin
                want = crossings_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic send_pair(pair_t p);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, p.rb, p.by, p.bx, p.ra, p.ay, p.ax};
        do
            @(posedge clk);
        while (!s_tready);
        crossings_due.push_back(solve_circles(p, eps_model));
    endtask

    task automatic wait_idle();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (crossings_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [cpi_pkg::EPS_W-1:0] value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= cpi_pkg::CFG_AW'(cpi_pkg::REG_EPSILON) << 2;
        pwdata <= cpi_pkg::CFG_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        eps_model = value;
        @(posedge clk);
    endtask

    function automatic pair_t make_pair();
        pair_t p;
        int    sc;
        int    kind;
        logic [31:0] span;
        kind = $urandom_range(0, 9);
        sc = $urandom_range(4, 29);
        span = 32'(1) << sc;
        p.ax = $urandom;
        p.ay = $urandom;
        if ($urandom_range(0, 1))
        begin
            p.ax = p.ax >>> (31 - sc);
            p.ay = p.ay >>> (31 - sc);
        end
        p.ra = 31'($urandom_range(1, span));
        p.rb = 31'($urandom_range(1, span));
        p.bx = p.ax + $signed($urandom_range(0, 2 * span)) - $signed(span);
        p.by = p.ay + $signed($urandom_range(0, 2 * span)) - $signed(span);
        case (kind)
            6:
            begin
                p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            end
            7:
            begin
                p.bx = p.ax + $signed($urandom_range(0, 4)) - 2;
                p.by = p.ay + $signed($urandom_range(0, 4)) - 2;
            end
            8:
            begin
                p.rb = p.ra >> $urandom_range(1, 4);
                p.bx = p.ax + $signed(32'(p.ra >> 3));
            end
            9:
            begin
                p.bx = p.ax + $signed(32'(p.ra) + 32'(p.rb));
                p.by = p.ay + $signed($urandom_range(0, 2)) - 1;
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                calm = $urandom_range(0, 3) == 0;
            send_pair(make_pair());
        end
        calm = 1'b0;
    endtask

    task automatic test_directed();
        pair_t p;
        p = '0;
        send_pair(p);
        p = '{32'h80000000, 32'h80000000, 31'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 31'h7fffffff};
        send_pair(p);
        p = '{32'h7fffffff, 32'h7fff0000, 31'h40000000,
              32'h7fefffff, 32'h7fff0000, 31'h40000000};
        send_pair(p);
        p = '{32'h80000000, 32'h80000000, 31'h40000000,
              32'h80100000, 32'h80000000, 31'h40000000};
        send_pair(p);
        p = '{0, 0, 31'h30000, 32'h50000, 0, 31'h20000};
        send_pair(p);
        p = '{0, 0, 31'h30000, 32'h10000, 0, 31'h20000};
        send_pair(p);
        p = '{0, 0, 31'h50000, 32'h10000, 0, 31'h10000};
        send_pair(p);
        p = '{0, 0, 31'h20000, 32'h20000, 0, 31'h20000};
        send_pair(p);
        p = '{0, 0, 31'h20000, 32'hfffe0000, 0, 31'h20000};
        send_pair(p);
        p = '{0, 0, 31'h20000, 0, 32'h20000, 31'h20000};
        send_pair(p);
        p = '{0, 0, 31'h20000, 0, 32'hfffe0000, 31'h20000};
        send_pair(p);
        p = '{0, 0, 31'h20000, 32'h18000, 32'hfffe8000, 31'h20000};
        send_pair(p);
        p = '{32'h1000, 32'h1000, 31'h10, 32'h1000, 32'h1001, 31'h10};
        send_pair(p);
        p = '{0, 0, 31'h10000, 32'h30000, 0, 31'h10000};
        send_pair(p);
        p = '{32'hffff0000, 32'h00010000, 31'h7fffffff,
              32'h00010000, 32'hffff0000, 31'h00000001};
        send_pair(p);
        p = '{32'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa,
              32'haaaaaaaa, 32'h55555555, 31'h55555555};
        send_pair(p);
        p = '{0, 0, 31'h1, 32'h1, 0, 31'h1};
        send_pair(p);
        p = '{0, 0, 0, 0, 0, 0};
        send_pair(p);
    endtask

    task automatic test_epsilon_sweep();
        write_epsilon('0);
        send_random(280);
        write_epsilon('1);
        send_random(280);
        write_epsilon(cpi_pkg::EPS_W'($urandom));
        send_random(300);
    endtask

    task automatic test_output_stall();
        rx_hold = 1500;
        calm = 1'b1;
        send_random(200);
    endtask

    task automatic test_drain_pause();
        send_random(60);
        wait_idle();
        send_random(60);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        eps_model = cpi_pkg::EPS_RESET;
        rx_hold = 0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_epsilon_sweep();
        test_output_stall();
        write_epsilon(cpi_pkg::EPS_RESET);
        test_drain_pause();
        wait_idle();
        if (mismatches == 0 && crossings_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
